>>> design/yaz0_pkg.sv
// yaz0_pkg: shared types, codes and constants of the yaz0 stream decompressor
// used by every module in design/, depends on nothing
package yaz0_pkg;

   localparam int WINDOW_BYTES_DEF = 4096;
   localparam int OUT_LANES_DEF    = 8;
   localparam int HDR_BYTES        = 16;
   localparam int CMDQ_DEPTH       = 4;

   localparam logic [7:0] CTRL_MSB    = 8'h80;
   localparam logic [3:0] DIST_NIBBLE = 4'h0f;
   localparam logic [8:0] EXT_BIAS    = 9'h012;
   localparam logic [8:0] SHORT_BIAS  = 9'd2;
   localparam logic [4:0] SIZE_FIRST  = 5'd4;
   localparam logic [4:0] SIZE_LAST   = 5'd7;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BAD_HEADER = 3'd1,
      ST_EOF_CTRL   = 3'd2,
      ST_EOF_LIT    = 3'd3,
      ST_EOF_REF    = 3'd4,
      ST_EOF_EXT    = 3'd5,
      ST_TOO_FAR    = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_DATA,
      PH_DRAIN
   } phase_type;

   typedef enum logic [1:0] {
      TK_FLAG_OR_LIT,
      TK_REF_LOW,
      TK_EXT_LEN
   } token_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_LIT,
      BK_READ,
      BK_WRITE,
      BK_EMIT
   } back_state_type;

   // one unit of work for the back end
   typedef struct packed {
      logic       is_lit;
      logic [7:0] lit_byte;
      logic [12:0] copy_dist;
      logic [8:0] len;
      logic       ended;
      status_type code;
   } cmd_type;

   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] r;
      case (idx)
         2'd0:    r = 8'h59;
         2'd1:    r = 8'h61;
         2'd2:    r = 8'h7a;
         default: r = 8'h30;
      endcase
      return r;
   endfunction

endpackage

>>> design/yaz0_front.sv
// yaz0_front: header check and token parsing, one input byte per cycle while the command queue has room
// depends on yaz0_pkg; emits cmd_type transactions into the command queue
module yaz0_front #(
   parameter int WINDOW_BYTES = yaz0_pkg::WINDOW_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [7:0]       in_byte,
   input  logic             in_last,
   input  logic             q_ready,
   output logic             in_ready,
   output logic             push,
   output yaz0_pkg::cmd_type push_cmd
);
   import yaz0_pkg::*;

   localparam int PW = $clog2(WINDOW_BYTES) + 1;

   phase_type   phase_ff, phase_in;
   logic [4:0]  hpos_ff, hpos_in;
   logic [31:0] target_ff, target_in;
   logic [31:0] remain_ff, remain_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic [7:0]  flags_ff, flags_in;
   logic [3:0]  fleft_ff, fleft_in;
   token_type   step_ff, step_in;
   logic [7:0]  refb_ff, refb_in;
   logic [12:0] dist_ff, dist_in;

   logic        accept;
   logic        ended;
   status_type  code;
   logic        do_copy;
   logic [8:0]  run;
   logic [12:0] cdist;
   logic [12:0] dist_new;
   logic [8:0]  eff;
   logic        do_lit;
   logic [PW:0] prod_sum;

   assign in_ready = q_ready;
   assign accept   = in_valid && q_ready;
   assign dist_new = {1'b0, refb_ff[3:0], in_byte} + 13'd1;

   always_comb begin
      phase_in  = phase_ff;
      hpos_in   = hpos_ff;
      target_in = target_ff;
      remain_in = remain_ff;
      prod_in   = prod_ff;
      flags_in  = flags_ff;
      fleft_in  = fleft_ff;
      step_in   = step_ff;
      refb_in   = refb_ff;
      dist_in   = dist_ff;
      ended     = 1'b0;
      code      = ST_OK;
      do_copy   = 1'b0;
      do_lit    = 1'b0;
      run       = '0;
      cdist     = dist_ff;
      eff       = '0;
      prod_sum  = '0;

      case (phase_ff)
         PH_HEADER: begin
            if (hpos_ff < SIZE_FIRST && in_byte != magic_byte(hpos_ff[1:0])) begin
               ended = 1'b1;
               code  = ST_BAD_HEADER;
            end else begin
               if (hpos_ff >= SIZE_FIRST && hpos_ff <= SIZE_LAST) begin
                  target_in = {target_ff[23:0], in_byte};
               end
               hpos_in = hpos_ff + 5'd1;
               if (hpos_in >= 5'(HDR_BYTES)) begin
                  if (target_in == '0) begin
                     ended = 1'b1;
                  end else begin
                     phase_in  = PH_DATA;
                     remain_in = target_in;
                  end
               end else if (in_last) begin
                  ended = 1'b1;
                  code  = ST_BAD_HEADER;
               end
            end
         end
         PH_DATA: begin
            if (fleft_ff == '0) begin
               flags_in = in_byte;
               fleft_in = 4'd8;
            end else begin
               case (step_ff)
                  TK_FLAG_OR_LIT: begin
                     if ((flags_ff & CTRL_MSB) != '0) begin
                        do_lit = 1'b1;
                     end else begin
                        refb_in = in_byte;
                        step_in = TK_REF_LOW;
                     end
                  end
                  TK_REF_LOW: begin
                     dist_in = dist_new;
                     cdist   = dist_new;
                     if (refb_ff[7:4] != '0) begin
                        do_copy = 1'b1;
                        run     = {5'd0, refb_ff[7:4]} + SHORT_BIAS;
                     end else begin
                        step_in = TK_EXT_LEN;
                     end
                  end
                  default: begin
                     do_copy = 1'b1;
                     run     = {1'b0, in_byte} + EXT_BIAS;
                  end
               endcase
            end
            if (do_lit) begin
               eff = 9'd1;
            end
            if (do_copy) begin
               if (cdist > 13'(prod_ff)) begin
                  ended = 1'b1;
                  code  = ST_TOO_FAR;
               end else begin
                  eff = (remain_ff < 32'(run)) ? remain_ff[8:0] : run;
               end
            end
            if (do_lit || (do_copy && !ended)) begin
               remain_in = remain_ff - 32'(eff);
               prod_sum  = {1'b0, prod_ff} + (PW+1)'(eff);
               prod_in   = (prod_sum > (PW+1)'(WINDOW_BYTES)) ? PW'(WINDOW_BYTES)
                                                              : prod_sum[PW-1:0];
               flags_in  = {flags_ff[6:0], 1'b0};
               fleft_in  = fleft_ff - 4'd1;
               step_in   = TK_FLAG_OR_LIT;
            end
         end
         default: begin
         end
      endcase

      // end of stream checks after the byte is taken in
      if (phase_in == PH_DATA && !ended) begin
         if (remain_in == '0) begin
            ended = 1'b1;
            code  = ST_OK;
         end else if (in_last) begin
            ended = 1'b1;
            if (fleft_in == '0) begin
               code = ST_EOF_CTRL;
            end else if (step_in == TK_FLAG_OR_LIT) begin
               code = ((flags_in & CTRL_MSB) != '0) ? ST_EOF_LIT : ST_EOF_REF;
            end else if (step_in == TK_REF_LOW) begin
               code = ST_EOF_REF;
            end else begin
               code = ST_EOF_EXT;
            end
         end
      end
      if (ended) begin
         phase_in = PH_DRAIN;
      end
      if (in_last) begin
         phase_in  = PH_HEADER;
         hpos_in   = '0;
         target_in = '0;
         remain_in = '0;
         prod_in   = '0;
         flags_in  = '0;
         fleft_in  = '0;
         step_in   = TK_FLAG_OR_LIT;
         refb_in   = '0;
         dist_in   = '0;
      end
   end

   always_comb begin
      push_cmd.is_lit    = do_lit;
      push_cmd.lit_byte  = in_byte;
      push_cmd.copy_dist = cdist;
      push_cmd.len       = eff;
      push_cmd.ended     = ended;
      push_cmd.code      = code;
      push               = accept && (eff != '0 || ended);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         hpos_ff   <= '0;
         target_ff <= '0;
         remain_ff <= '0;
         prod_ff   <= '0;
         flags_ff  <= '0;
         fleft_ff  <= '0;
         step_ff   <= TK_FLAG_OR_LIT;
         refb_ff   <= '0;
         dist_ff   <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         hpos_ff   <= hpos_in;
         target_ff <= target_in;
         remain_ff <= remain_in;
         prod_ff   <= prod_in;
         flags_ff  <= flags_in;
         fleft_ff  <= fleft_in;
         step_ff   <= step_in;
         refb_ff   <= refb_in;
         dist_ff   <= dist_in;
      end
   end

endmodule

>>> design/yaz0_cmd_fifo.sv
// yaz0_cmd_fifo: short command queue between front and back end
// depends on yaz0_pkg for cmd_type and the queue depth
module yaz0_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  yaz0_pkg::cmd_type push_cmd,
   input  logic              pop,
   output logic              not_full,
   output logic              not_empty,
   output yaz0_pkg::cmd_type head
);
   import yaz0_pkg::*;

   localparam int AW = $clog2(CMDQ_DEPTH);

   cmd_type     slot_ff [CMDQ_DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0] cnt_ff, cnt_in;

   assign not_full  = cnt_ff != (AW+1)'(CMDQ_DEPTH);
   assign not_empty = cnt_ff != '0;
   assign head      = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + AW'(1) : wr_ff;
      rd_in  = pop ? rd_ff + AW'(1) : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

>>> design/yaz0_back.sv
// yaz0_back: runs literals and copies through the history memory, packs output
// depends on yaz0_pkg; owns the history memory and the output register
module yaz0_back #(
   parameter int WINDOW_BYTES = yaz0_pkg::WINDOW_BYTES_DEF,
   parameter int OUT_LANES    = yaz0_pkg::OUT_LANES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  yaz0_pkg::cmd_type q_head,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [63:0]       rsp_out_bytes,
   output logic [3:0]        rsp_out_count,
   output logic              rsp_run_end,
   output logic              rsp_stream_end,
   output logic [2:0]        rsp_status
);
   import yaz0_pkg::*;

   localparam int AW = $clog2(WINDOW_BYTES);

   logic [7:0]     hist_mem [WINDOW_BYTES];
   logic [7:0]     rd_data_ff;

   back_state_type state_ff, state_in;
   cmd_type        cur_ff, cur_in;
   logic [8:0]     left_ff, left_in;
   logic [AW-1:0]  wptr_ff, wptr_in;
   logic [63:0]    pack_ff, pack_in;
   logic [3:0]     pcnt_ff, pcnt_in;
   logic           final_ff, final_in;

   logic           ov_ff, ov_in;
   logic [63:0]    ob_ff, ob_in;
   logic [3:0]     oc_ff, oc_in;
   logic           ore_ff, ore_in;
   logic           ose_ff, ose_in;
   logic [2:0]     ost_ff, ost_in;

   logic           wr_en;
   logic [7:0]     wr_data;
   logic [AW-1:0]  rd_addr;
   logic           out_free;

   assign out_free = !ov_ff || rsp_ready;
   assign rd_addr  = wptr_ff - cur_ff.copy_dist[AW-1:0];

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      left_in  = left_ff;
      wptr_in  = wptr_ff;
      pack_in  = pack_ff;
      pcnt_in  = pcnt_ff;
      final_in = final_ff;
      ov_in    = ov_ff && !rsp_ready;
      ob_in    = ob_ff;
      oc_in    = oc_ff;
      ore_in   = ore_ff;
      ose_in   = ose_ff;
      ost_in   = ost_ff;
      wr_en    = 1'b0;
      wr_data  = cur_ff.lit_byte;
      q_pop    = 1'b0;

      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               cur_in  = q_head;
               left_in = q_head.len;
               if (q_head.is_lit) begin
                  state_in = BK_LIT;
               end else if (q_head.len == '0) begin
                  final_in = 1'b1;
                  state_in = BK_EMIT;
               end else begin
                  state_in = BK_READ;
               end
            end
         end
         BK_LIT: begin
            wr_en    = 1'b1;
            wptr_in  = wptr_ff + AW'(1);
            pack_in  = {56'd0, cur_ff.lit_byte};
            pcnt_in  = 4'd1;
            final_in = 1'b1;
            state_in = BK_EMIT;
         end
         BK_READ: begin
            left_in  = left_ff - 9'd1;
            state_in = BK_WRITE;
         end
         BK_WRITE: begin
            wr_en   = 1'b1;
            wr_data = rd_data_ff;
            wptr_in = wptr_ff + AW'(1);
            pack_in[pcnt_ff[2:0]*8 +: 8] = rd_data_ff;
            pcnt_in = pcnt_ff + 4'd1;
            if (left_ff == '0 || pcnt_in == 4'(OUT_LANES)) begin
               final_in = left_ff == '0;
               state_in = BK_EMIT;
            end else begin
               state_in = BK_READ;
            end
         end
         BK_EMIT: begin
            if (out_free) begin
               ov_in    = 1'b1;
               ob_in    = pack_ff;
               oc_in    = pcnt_ff;
               ore_in   = final_ff;
               ose_in   = final_ff && cur_ff.ended;
               ost_in   = (final_ff && cur_ff.ended) ? cur_ff.code : ST_OK;
               pack_in  = '0;
               pcnt_in  = '0;
               final_in = 1'b0;
               state_in = final_ff ? BK_IDLE : BK_READ;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         wptr_ff  <= '0;
         pack_ff  <= '0;
         pcnt_ff  <= '0;
         final_ff <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         wptr_ff  <= wptr_in;
         pack_ff  <= pack_in;
         pcnt_ff  <= pcnt_in;
         final_ff <= final_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      left_ff <= left_in;
      ob_ff   <= ob_in;
      oc_ff   <= oc_in;
      ore_ff  <= ore_in;
      ose_ff  <= ose_in;
      ost_ff  <= ost_in;
   end

   // history: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[wptr_ff] <= wr_data;
      end
      rd_data_ff <= hist_mem[rd_addr];
   end

   assign rsp_valid      = ov_ff;
   assign rsp_out_bytes  = ob_ff;
   assign rsp_out_count  = oc_ff;
   assign rsp_run_end    = ore_ff;
   assign rsp_stream_end = ose_ff;
   assign rsp_status     = ost_ff;

endmodule

>>> design/yaz0_stream_decompressor.sv
// yaz0_stream_decompressor: top level of the yaz0 decompressor
// depends on yaz0_pkg, yaz0_front, yaz0_cmd_fifo and yaz0_back
//
// usage:
//   req channel takes the compressed file one byte per transaction, with
//   req_in_last on the final byte; rsp channel gives packs of up to
//   OUT_LANES decompressed bytes, earliest byte in the low lane.
//   rsp_run_end marks the last pack caused by one input byte, rsp_stream_end
//   the pack that ends the stream, carrying rsp_status.
// timing:
//   the front parses one byte per cycle while the command queue has room.
//   the back end handles a literal in the states idle, lit and emit, an empty
//   pack in idle and emit, and a copy with a start in idle, then a read and a
//   write state per byte (registered history read, then write, so the next read
//   sees it) and an emit state per pack. it finishes one command before the next.
// reset: clears all control state, the block then waits for a header.
//   history content is not cleared; it is only read after being written.
// stall: when rsp_ready is low the output register holds, the back end
//   stops, the queue fills and req_ready drops.
module yaz0_stream_decompressor #(
   parameter int WINDOW_BYTES = yaz0_pkg::WINDOW_BYTES_DEF,
   parameter int OUT_LANES    = yaz0_pkg::OUT_LANES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_out_bytes,
   output logic [3:0]  rsp_out_count,
   output logic        rsp_run_end,
   output logic        rsp_stream_end,
   output logic [2:0]  rsp_status
);
   import yaz0_pkg::*;

   logic    push, q_not_full, q_not_empty, q_pop;
   cmd_type push_cmd, q_head;

   yaz0_front #(.WINDOW_BYTES(WINDOW_BYTES)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_byte  (req_in_byte),
      .in_last  (req_in_last),
      .q_ready  (q_not_full),
      .in_ready (req_ready),
      .push     (push),
      .push_cmd (push_cmd)
   );

   yaz0_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (q_pop),
      .not_full  (q_not_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   yaz0_back #(.WINDOW_BYTES(WINDOW_BYTES), .OUT_LANES(OUT_LANES)) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_not_empty),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_bytes  (rsp_out_bytes),
      .rsp_out_count  (rsp_out_count),
      .rsp_run_end    (rsp_run_end),
      .rsp_stream_end (rsp_stream_end),
      .rsp_status     (rsp_status)
   );

   // packs that do not close a run are always full
   a_full_pack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_end |-> rsp_out_count == 4'(OUT_LANES))
      else $error("partial pack before run end");

   // an error status only on the transaction that ends the stream
   a_status_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_stream_end)
      else $error("status without stream end");

   // stream end always closes the run
   a_end_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_end |-> rsp_run_end)
      else $error("stream end inside a run");

endmodule

>>> verif/tb.sv
// tb: self-checking testbench for yaz0_stream_decompressor, directed and random yaz0 files
// depends on design/yaz0_pkg.sv and the decompressor rtl under design/
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import yaz0_pkg::*;

   typedef struct packed {
      logic [63:0] bytes;
      logic [3:0]  count;
      logic        run_end;
      logic        stream_end;
      status_type  status;
   } pack_type;

   localparam int IDLE_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte = 8'h00;
   logic        req_in_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_out_bytes;
   logic [3:0]  rsp_out_count;
   logic        rsp_run_end;
   logic        rsp_stream_end;
   logic [2:0]  rsp_status;

   yaz0_stream_decompressor dut (.*);

   always #10 clock = ~clock;

   // decoder shadow state
   phase_type   dec_phase;
   int unsigned hdr_pos, out_size, out_made, ref_dist;
   logic [7:0]  ctrl_flags, ref_hi;
   int unsigned flags_left;
   token_type   tok_step;
   logic [7:0]  window_mem [WINDOW_BYTES_DEF];
   logic [7:0]  step_bytes [$];
   logic [7:0]  yaz_magic [4] = '{8'h59, 8'h61, 8'h7a, 8'h30};

   pack_type    pack_q [$];
   logic [7:0]  file_q [$];
   int          mismatches = 0, packs_seen = 0, bytes_sent = 0, files_sent = 0;
   int          burst_left = 0, idle_cycles = 0;
   int unsigned ready_cyc = 0;

   function void clear_stream();
      dec_phase  = PH_HEADER;
      hdr_pos    = 0;
      out_size   = 0;
      out_made   = 0;
      ctrl_flags = 8'h00;
      flags_left = 0;
      tok_step   = TK_FLAG_OR_LIT;
      ref_hi     = 8'h00;
      ref_dist   = 0;
   endfunction

   function void put_out(input logic [7:0] v);
      window_mem[out_made % WINDOW_BYTES_DEF] = v;
      out_made++;
      step_bytes.insert(step_bytes.size(), v);
   endfunction

   function void end_token();
      ctrl_flags = ctrl_flags << 1;
      if (flags_left > 0) flags_left--;
      tok_step = TK_FLAG_OR_LIT;
   endfunction

   function status_type copy_run(input int unsigned run);
      int unsigned i;
      if (ref_dist > out_made) return ST_TOO_FAR;
      for (i = 0; i < run && out_made < out_size; i++)
         put_out(window_mem[(out_made - ref_dist) % WINDOW_BYTES_DEF]);
      end_token();
      return ST_OK;
   endfunction

   // expected packs for one accepted compressed byte
   function void decode_byte(input logic [7:0] b, input logic last);
      logic       ended;
      status_type code;
      int         npacks, k, lane;
      pack_type   p;
      ended = 1'b0;
      code  = ST_OK;
      step_bytes.delete();
      if (dec_phase == PH_HEADER) begin
         if (hdr_pos < 4 && b != yaz_magic[hdr_pos]) begin
            ended = 1'b1;
            code  = ST_BAD_HEADER;
         end else begin
            if (hdr_pos >= 4 && hdr_pos < 8) out_size = (out_size << 8) | b;
            hdr_pos++;
            if (hdr_pos >= HDR_BYTES) begin
               if (out_size == 0) ended = 1'b1;
               else dec_phase = PH_DATA;
            end else if (last) begin
               ended = 1'b1;
               code  = ST_BAD_HEADER;
            end
         end
      end else if (dec_phase == PH_DATA) begin
         if (flags_left == 0) begin
            ctrl_flags = b;
            flags_left = 8;
         end else if (tok_step == TK_FLAG_OR_LIT) begin
            if (ctrl_flags[7]) begin
               put_out(b);
               end_token();
            end else begin
               ref_hi   = b;
               tok_step = TK_REF_LOW;
            end
         end else if (tok_step == TK_REF_LOW) begin
            ref_dist = {ref_hi[3:0], b} + 1;
            if (ref_hi[7:4] != 4'h0) begin
               code  = copy_run(ref_hi[7:4] + 2);
               ended = (code != ST_OK);
            end else begin
               tok_step = TK_EXT_LEN;
            end
         end else begin
            code  = copy_run(b + 18);
            ended = (code != ST_OK);
         end
      end
      if (dec_phase == PH_DATA && !ended) begin
         if (out_made >= out_size) begin
            ended = 1'b1;
            code  = ST_OK;
         end else if (last) begin
            ended = 1'b1;
            if (flags_left == 0) code = ST_EOF_CTRL;
            else if (tok_step == TK_FLAG_OR_LIT) code = ctrl_flags[7] ? ST_EOF_LIT : ST_EOF_REF;
            else if (tok_step == TK_REF_LOW) code = ST_EOF_REF;
            else code = ST_EOF_EXT;
         end
      end
      if (ended) dec_phase = PH_DRAIN;
      if (last) clear_stream();
      npacks = (step_bytes.size() + 7) / 8;
      if (npacks == 0 && ended) npacks = 1;
      for (k = 0; k < npacks; k++) begin
         p = '0;
         for (lane = 0; lane < 8 && k * 8 + lane < step_bytes.size(); lane++) begin
            p.bytes[lane*8 +: 8] = step_bytes[k*8 + lane];
            p.count++;
         end
         p.run_end    = (k + 1 == npacks);
         p.stream_end = (k + 1 == npacks) && ended;
         p.status     = p.stream_end ? code : ST_OK;
         pack_q.insert(pack_q.size(), p);
      end
   endfunction

   // one transaction on the request side, bursts with random gaps
   task send_byte(input logic [7:0] b, input logic last);
      if (burst_left == 0) begin
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 10);
      end
      req_valid   = 1'b1;
      req_in_byte = b;
      req_in_last = last;
      do @(posedge clock); while (!req_ready);
      decode_byte(b, last);
      bytes_sent++;
      burst_left--;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task send_file();
      int i;
      for (i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == file_q.size() - 1);
      files_sent++;
      file_q.delete();
   endtask

   task wait_drained();
      while (pack_q.size() != 0) @(negedge clock);
   endtask

   function void add_byte(input logic [7:0] b);
      file_q.insert(file_q.size(), b);
   endfunction

   function void add_header(input int unsigned size);
      int k;
      for (k = 0; k < 4; k++) add_byte(yaz_magic[k]);
      for (k = 3; k >= 0; k--) add_byte(size[k*8 +: 8]);
      for (k = 0; k < 8; k++) add_byte(8'($urandom));
   endfunction

   // well-formed body that produces at least size bytes
   function void add_body(input int unsigned size);
      int unsigned made, offset, len, i;
      int          j;
      logic [7:0]  ctrl;
      logic [7:0]  tok [$];
      made = 0;
      while (made < size) begin
         ctrl = 8'($urandom);
         tok.delete();
         for (i = 0; i < 8 && made < size; i++) begin
            if (made == 0 || $urandom_range(0, 2) == 0) begin
               ctrl[7-i] = 1'b1;
               tok.insert(tok.size(), 8'($urandom));
               made++;
            end else begin
               ctrl[7-i] = 1'b0;
               offset = $urandom_range(1, made > 4096 ? 4096 : made) - 1;
               if ($urandom_range(0, 3) == 0) begin
                  len = $urandom_range(18, 273);
                  tok.insert(tok.size(), {4'h0, offset[11:8]});
                  tok.insert(tok.size(), offset[7:0]);
                  tok.insert(tok.size(), 8'(len - 18));
               end else begin
                  len = $urandom_range(3, 17);
                  tok.insert(tok.size(), {len[3:0] - 4'd2, offset[11:8]});
                  tok.insert(tok.size(), offset[7:0]);
               end
               made += len;
            end
         end
         add_byte(ctrl);
         for (j = 0; j < tok.size(); j++) add_byte(tok[j]);
      end
   endfunction

   task test_header_errors();
      file_q = '{8'h59, 8'h62, 8'h00};                        // bad magic, then dropped
      send_file();
      file_q = '{8'h59, 8'h61, 8'h7a, 8'h30, 8'h00};          // short header
      send_file();
      add_header(0);                                          // zero size
      send_file();
   endtask

   task test_long_copies();
      // literals, extended run of 273, short runs, 300 bytes out
      add_header(300);
      file_q = {file_q, 8'b11100011, 8'h00, 8'hff, 8'ha5, 8'h00, 8'h02, 8'hff,
                8'hf0, 8'h00, 8'h30, 8'h05, 8'h11, 8'h22};
      send_file();
   endtask

   task test_body_errors();
      add_header(10);
      file_q = {file_q, 8'h00, 8'h10, 8'h00};                 // distance too far
      send_file();
      add_header(10);                                         // eof in control
      send_file();
      add_header(10);
      add_byte(8'h80);                                        // eof in literal
      send_file();
      add_header(10);
      add_byte(8'h00);                                        // eof in reference
      send_file();
      add_header(10);
      file_q = {file_q, 8'h80, 8'haa, 8'h00, 8'h00};          // eof in extended length
      send_file();
   endtask

   task test_pause_until_drained();
      int unsigned size;
      size = $urandom_range(3, 8);
      add_header(size);
      add_body(size);
      add_byte(8'($urandom));                                 // trailing byte, dropped
      send_file();
      wait_drained();
   endtask

   // receiver stall pattern: free, random, heavy stall, square wave
   always @(negedge clock) begin
      ready_cyc++;
      case ((ready_cyc >> 7) % 4)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= 1'($urandom_range(0, 1));
         2:       rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= ready_cyc[3];
      endcase
   end

   always @(posedge clock) begin
      pack_type exp_p;
      if (!reset && rsp_valid && rsp_ready) begin
         packs_seen++;
         if (pack_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction: bytes %h count %0d",
                                           rsp_out_bytes, rsp_out_count);
         end else begin
            exp_p = pack_q.pop_front();
            if (rsp_out_bytes !== exp_p.bytes || rsp_out_count !== exp_p.count ||
                rsp_run_end !== exp_p.run_end || rsp_stream_end !== exp_p.stream_end ||
                rsp_status !== exp_p.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp %h/%0d/%b/%b/%0d got %h/%0d/%b/%b/%0d",
                           exp_p.bytes, exp_p.count, exp_p.run_end, exp_p.stream_end,
                           exp_p.status, rsp_out_bytes, rsp_out_count, rsp_run_end,
                           rsp_stream_end, rsp_status);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      clear_stream();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_header_errors();
      test_long_copies();
      test_body_errors();
      test_pause_until_drained();
      wait_drained();
      repeat (40) @(posedge clock);
      $display("covered %0d files, %0d compressed bytes, %0d output packs checked",
               files_sent, bytes_sent, packs_seen);
      $display("mismatches %0d, packs still expected %0d", mismatches, pack_q.size());
      if (mismatches == 0 && pack_q.size() == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end
endmodule
